[hw/rtl/fixed_point_q24_8_alu_unit_assert.svh]
// Assertion macros used by the top module of the fixed-point ALU.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fpq assertion failed");
`define FPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fpq implication failed");
`else
`define FPQ_ASSERT(lbl, clk, rstn, prop)
`define FPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/fpq_pkg.sv]
`timescale 1ns / 1ps
package fpq_pkg;
  localparam int unsigned WordBits = 32;
  localparam int unsigned AccBits  = 2 * WordBits;

  localparam logic [3:0] OpAdd   = 4'd0;
  localparam logic [3:0] OpSub   = 4'd1;
  localparam logic [3:0] OpMul   = 4'd2;
  localparam logic [3:0] OpDiv   = 4'd3;
  localparam logic [3:0] OpGt    = 4'd4;
  localparam logic [3:0] OpLt    = 4'd5;
  localparam logic [3:0] OpGe    = 4'd6;
  localparam logic [3:0] OpLe    = 4'd7;
  localparam logic [3:0] OpEq    = 4'd8;
  localparam logic [3:0] OpNe    = 4'd9;
  localparam logic [3:0] OpMin   = 4'd10;
  localparam logic [3:0] OpMax   = 4'd11;
  localparam logic [3:0] OpInc   = 4'd12;
  localparam logic [3:0] OpDec   = 4'd13;
  localparam logic [3:0] OpToInt = 4'd14;
  localparam logic [3:0] OpFrInt = 4'd15;

  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StOvf = 2'd1;
  localparam logic [1:0] StDz  = 2'd2;

  localparam logic [WordBits-1:0] PosLimit = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] NegLimit = {1'b1, {(WordBits-1){1'b0}}};

  typedef struct packed {
    logic [3:0]                 req_type;
    logic signed [WordBits-1:0] operand_a;
    logic signed [WordBits-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WordBits-1:0] result_value;
    logic                       compare_true;
    logic [1:0]                 status;
  } resp_t;

  typedef struct packed {
    logic                vld;
    logic                is_mul;
    logic                is_div;
    logic                neg;
    logic [WordBits-1:0] x;
    logic [WordBits-1:0] y;
    logic [AccBits-1:0]  acc;
    logic [WordBits:0]   rem;
    logic [WordBits-1:0] res;
    logic                cmp;
    logic [1:0]          st;
  } lane_t;
endpackage

[hw/rtl/fpq_cell.sv]
`timescale 1ns / 1ps
module fpq_cell #(
  parameter int unsigned Idx      = 0,
  parameter int unsigned FracBits = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  fpq_pkg::lane_t lane_i,
  output fpq_pkg::lane_t lane_o
);
  import fpq_pkg::*;

  localparam int unsigned NumW = WordBits + FracBits;

  lane_t              d;
  lane_t              q;
  logic               vld_q;
  logic [WordBits:0]  r2;
  logic [WordBits:0]  diff;
  logic               ge;
  logic [AccBits-1:0] mul_term;

  if (Idx < WordBits) begin : g_mul
    assign mul_term = lane_i.y[Idx] ? ({{WordBits{1'b0}}, lane_i.x} << Idx) : '0;
  end else begin : g_nomul
    assign mul_term = '0;
  end

  always_comb begin
    d    = lane_i;
    r2   = {lane_i.rem[WordBits-1:0], lane_i.acc[NumW-1]};
    diff = r2 - {1'b0, lane_i.y};
    ge   = r2 >= {1'b0, lane_i.y};
    if (lane_i.is_div) begin
      d.rem = ge ? diff : r2;
      d.acc = {lane_i.acc[AccBits-2:0], ge};
    end else if (lane_i.is_mul) begin
      d.acc = lane_i.acc + mul_term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= lane_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q <= d;
    end
  end

  always_comb begin
    lane_o     = q;
    lane_o.vld = vld_q;
  end
endmodule

[hw/rtl/fpq_round.sv]
`timescale 1ns / 1ps
module fpq_round #(
  parameter int unsigned FracBits = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  fpq_pkg::lane_t lane_i,
  output logic           out_valid_o,
  output fpq_pkg::resp_t out_data_o
);
  import fpq_pkg::*;

  localparam int unsigned NumW = WordBits + FracBits;

  logic [AccBits-1:0] prod;
  logic [AccBits-1:0] qm;
  logic [AccBits-1:0] qd;
  logic [AccBits-1:0] qmag;
  logic [AccBits-1:0] lim;
  logic [WordBits:0]  gap;
  logic               rnd;
  resp_t              d;
  resp_t              q;
  logic               vld_q;

  always_comb begin
    prod = lane_i.acc + (AccBits'(1) << (FracBits - 1));
    qm   = prod >> FracBits;
    gap  = {1'b0, lane_i.y} - lane_i.rem;
    rnd  = lane_i.rem >= gap;
    qd   = AccBits'(lane_i.acc[NumW-1:0]) + AccBits'(rnd);
    qmag = lane_i.is_mul ? qm : qd;
    lim  = lane_i.neg ? AccBits'(NegLimit) : AccBits'(PosLimit);
    d.result_value = lane_i.res;
    d.compare_true = lane_i.cmp;
    d.status       = lane_i.st;
    if (lane_i.is_mul || lane_i.is_div) begin
      if (qmag > lim) begin
        d.result_value = lane_i.neg ? NegLimit : PosLimit;
        d.status       = StOvf;
      end else begin
        d.result_value = lane_i.neg ? -qmag[WordBits-1:0] : qmag[WordBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= lane_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q <= d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = q;
endmodule

[hw/rtl/fixed_point_q24_8_alu_unit.sv]
`timescale 1ns / 1ps
// Channel | Direction | Transfer when          | Payload
// in      | input     | in_valid_i & in_ready_o | in_data_i (req_type, operand_a, operand_b)
// out     | output    | out_valid_o & out_ready_i | out_data_o (result_value, compare_true, status)
// One transfer is taken every cycle while the output is not stalled; each result passes
// through the row of cells (one quotient bit or partial product each) and the output register.
// Reset clears the valid bit of every cell and of the output register.
// A stalled output holds the whole row, and the input is then not ready.
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fpq_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fpq_pkg::resp_t out_data_o
);
  import fpq_pkg::*;
`include "fixed_point_q24_8_alu_unit_assert.svh"

  localparam int unsigned NumCells = WordBits + FRACTION_BITS;

  lane_t                      lane [NumCells+1];
  lane_t                      head;
  logic                       adv;
  logic signed [WordBits-1:0] a;
  logic signed [WordBits-1:0] b;
  logic signed [WordBits-1:0] bb;
  logic signed [WordBits:0]   sum;
  logic signed [AccBits-1:0]  shl;
  logic                       addsub;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign a          = in_data_i.operand_a;
  assign b          = in_data_i.operand_b;

  always_comb begin
    addsub = (in_data_i.req_type == OpSub) || (in_data_i.req_type == OpDec);
    bb     = ((in_data_i.req_type == OpInc) || (in_data_i.req_type == OpDec)) ?
             WordBits'(1) : b;
    sum    = addsub ? ({a[WordBits-1], a} - {bb[WordBits-1], bb}) :
                      ({a[WordBits-1], a} + {bb[WordBits-1], bb});
    shl    = AccBits'(a) <<< FRACTION_BITS;
    head        = '0;
    head.vld    = in_valid_i;
    head.neg    = a[WordBits-1] ^ b[WordBits-1];
    head.x      = a[WordBits-1] ? -a : a;
    head.y      = b[WordBits-1] ? -b : b;
    head.st     = StOk;
    case (in_data_i.req_type)
      OpAdd, OpSub, OpInc, OpDec: begin
        if (sum[WordBits] != sum[WordBits-1]) begin
          head.res = sum[WordBits] ? NegLimit : PosLimit;
          head.st  = StOvf;
        end else begin
          head.res = sum[WordBits-1:0];
        end
      end
      OpMul: head.is_mul = 1'b1;
      OpDiv: begin
        if (b == '0) begin
          head.st = StDz;
        end else begin
          head.is_div = 1'b1;
          head.acc    = AccBits'(head.x) << FRACTION_BITS;
        end
      end
      OpGt:  head.cmp = a > b;
      OpLt:  head.cmp = a < b;
      OpGe:  head.cmp = a >= b;
      OpLe:  head.cmp = a <= b;
      OpEq:  head.cmp = a == b;
      OpNe:  head.cmp = a != b;
      OpMin: head.res = (a < b) ? a : b;
      OpMax: head.res = (b < a) ? a : b;
      OpToInt: head.res = a >>> FRACTION_BITS;
      default: begin
        if ((shl[AccBits-1:WordBits-1] != '0) && (shl[AccBits-1:WordBits-1] != '1)) begin
          head.res = a[WordBits-1] ? NegLimit : PosLimit;
          head.st  = StOvf;
        end else begin
          head.res = shl[WordBits-1:0];
        end
      end
    endcase
  end

  assign lane[0] = head;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    fpq_cell #(
      .Idx      (k),
      .FracBits (FRACTION_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .lane_i (lane[k]),
      .lane_o (lane[k+1])
    );
  end

  fpq_round #(
    .FracBits (FRACTION_BITS)
  ) u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .lane_i      (lane[NumCells]),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `FPQ_ASSERT(a_ready_follows_out, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))
  `FPQ_ASSERT_IMPL(a_dz_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status == StDz), out_data_o.result_value == '0)
  `FPQ_ASSERT_IMPL(a_cmp_clean, clk_i, rst_ni, out_valid_o && out_data_o.compare_true, (out_data_o.status == StOk) && (out_data_o.result_value == '0))
  `FPQ_ASSERT_IMPL(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 $stable(lane[NumCells].vld))
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import fpq_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Latency  = FracBits + 33;
  localparam longint CycleLimit    = 400000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  req_t  in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  resp_t out_data_o;

  resp_t  expected_q[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     items_sent = 0;
  longint cycles = 0;
  bit     quiet_phase = 1'b0;
  bit     hold_off = 1'b0;

  fixed_point_q24_8_alu_unit #(.FRACTION_BITS(FracBits)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] saturate(bit neg, logic [127:0] m, ref logic [1:0] st);
    if (!neg) begin
      if (m > 128'h7fffffff) begin
        st = StOvf;
        return PosLimit;
      end
      return m[31:0];
    end
    if (m > 128'h80000000) begin
      st = StOvf;
      return NegLimit;
    end
    return -m[31:0];
  endfunction

  function automatic resp_t alu_result(req_t r);
    resp_t o;
    logic signed [31:0] a, b;
    logic signed [32:0] s;
    logic [127:0] ma, mb, m;
    logic [1:0] st;
    o = '0;
    st = StOk;
    a = r.operand_a;
    b = r.operand_b;
    ma = a[31] ? 128'(-64'(a)) : 128'(a);
    mb = b[31] ? 128'(-64'(b)) : 128'(b);
    case (r.req_type)
      OpAdd, OpSub, OpInc, OpDec: begin
        case (r.req_type)
          OpAdd: s = 33'(a) + 33'(b);
          OpSub: s = 33'(a) - 33'(b);
          OpInc: s = 33'(a) + 33'sd1;
          default: s = 33'(a) - 33'sd1;
        endcase
        if (s > 33'sh7fffffff) begin
          st = StOvf;
          o.result_value = PosLimit;
        end else if (s < -33'sh80000000) begin
          st = StOvf;
          o.result_value = NegLimit;
        end else begin
          o.result_value = s[31:0];
        end
      end
      OpMul: begin
        m = (ma * mb + (128'd1 << (FracBits - 1))) >> FracBits;
        o.result_value = saturate(a[31] != b[31], m, st);
      end
      OpDiv: begin
        if (b == 0) begin
          st = StDz;
        end else begin
          m = (ma << FracBits) / mb;
          if ((((ma << FracBits) % mb) << 1) >= mb) m = m + 1;
          o.result_value = saturate(a[31] != b[31], m, st);
        end
      end
      OpGt: o.compare_true = a > b;
      OpLt: o.compare_true = a < b;
      OpGe: o.compare_true = a >= b;
      OpLe: o.compare_true = a <= b;
      OpEq: o.compare_true = a == b;
      OpNe: o.compare_true = a != b;
      OpMin: o.result_value = (a < b) ? a : b;
      OpMax: o.result_value = (b < a) ? a : b;
      OpToInt: o.result_value = a >>> FracBits;
      default: begin
        m = ma << FracBits;
        o.result_value = saturate(a[31], m, st);
      end
    endcase
    o.status = st;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("Mismatch on %s at cycle %0d: got %0h, expected %0h.", what, cycles, got, want);
  endtask

  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.result_value !== want.result_value)
          report_mismatch("result_value", out_data_o.result_value, want.result_value);
        if (out_data_o.compare_true !== want.compare_true)
          report_mismatch("compare_true", out_data_o.compare_true, want.compare_true);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
      end
    end
  end

  // The receiver stalls in bursts, or for a long stretch while hold_off is set.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    req_t r;
    int n;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    r.req_type = op;
    r.operand_a = a;
    r.operand_b = b;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(alu_result(r));
    items_sent++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return PosLimit - $urandom_range(0, 3);
      1: return NegLimit + $urandom_range(0, 3);
      2: return $urandom_range(0, 4) - 2;
      3: return 32'($signed($urandom_range(0, 4095)) - 2048);
      4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      5: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_item(OpAdd, PosLimit, 32'd1);
    send_item(OpAdd, NegLimit, 32'hffffffff);
    send_item(OpSub, NegLimit, 32'd1);
    send_item(OpSub, 32'd0, NegLimit);
    send_item(OpMul, PosLimit, PosLimit);
    send_item(OpMul, 32'd384, 32'hffffff80);
    send_item(OpMul, 32'd1, 32'd128);
    send_item(OpMul, NegLimit, 32'd256);
    send_item(OpDiv, 32'd256, 32'd0);
    send_item(OpDiv, 32'd256, 32'd768);
    send_item(OpDiv, NegLimit, 32'd1);
    send_item(OpDiv, 32'd1, 32'd2);
    send_item(OpDiv, 32'hffffff00, 32'd512);
    send_item(OpGt, 32'd5, 32'd5);
    send_item(OpLt, NegLimit, PosLimit);
    send_item(OpGe, 32'd5, 32'd5);
    send_item(OpLe, PosLimit, NegLimit);
    send_item(OpEq, 32'd7, 32'd7);
    send_item(OpNe, 32'd7, 32'd7);
    send_item(OpMin, 32'd9, 32'd9);
    send_item(OpMax, NegLimit, PosLimit);
    send_item(OpInc, PosLimit, 32'd0);
    send_item(OpDec, NegLimit, 32'd0);
    send_item(OpToInt, 32'hffffff01, 32'd0);
    send_item(OpFrInt, 32'h00800000, 32'd0);
  endtask

  task automatic test_random(int count);
    repeat (count) send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    test_random(150);
  endtask

  task automatic test_full_rate();
    quiet_phase = 1'b1;
    test_random(300);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1200);
    test_backpressure();
    test_full_rate();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);
    $display("Sent %0d items over all sixteen operations and checked %0d results,",
             items_sent, results_seen);
    $display("with random gaps on both sides, a long output stall and a full-rate tail.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
